>>> src/rqtrp_pkg.sv
package rqtrp_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MAX_REPORT = 64;
    localparam int ADDR_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int REP_BITS   = $clog2(MAX_REPORT + 1);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic              func;
        logic [7:0]        point_id;
        logic signed [31:0] point_rank;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] low_x;
        logic signed [31:0] high_x;
        logic signed [31:0] low_y;
        logic signed [31:0] high_y;
        logic [6:0]        max_count;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [7:0]        out_id;
        logic signed [31:0] out_rank;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]        id;
        logic signed [31:0] rank;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } entry_t;

    // classified command passed from front to back
    typedef struct packed {
        logic              is_query;
        entry_t            pt;
        logic signed [31:0] low_x;
        logic signed [31:0] high_x;
        logic signed [31:0] low_y;
        logic signed [31:0] high_y;
        logic [REP_BITS-1:0] limit;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_SHIFT,
        ST_LOAD_DONE,
        ST_Q_RD,
        ST_Q_CHK,
        ST_Q_FLUSH
    } back_state_t;

endpackage

>>> src/rqtrp_front.sv
module rqtrp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rqtrp_pkg::in_item_t in_data,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output rqtrp_pkg::cmd_t     cmd_data
);

    // two-entry command queue
    rqtrp_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    rqtrp_pkg::cmd_t c;
    logic push, pop;

    always_comb
    begin
        c = '0;
        c.is_query = (in_data.func == rqtrp_pkg::FUNC_QUERY);
        c.pt.id    = in_data.point_id;
        c.pt.rank  = in_data.point_rank;
        c.pt.x     = in_data.point_x;
        c.pt.y     = in_data.point_y;
        c.low_x    = in_data.low_x;
        c.high_x   = in_data.high_x;
        c.low_y    = in_data.low_y;
        c.high_y   = in_data.high_y;
        if (in_data.max_count == 7'd0)
            c.limit = rqtrp_pkg::REP_BITS'(1);
        else if (32'(in_data.max_count) > rqtrp_pkg::MAX_REPORT)
            c.limit = rqtrp_pkg::REP_BITS'(rqtrp_pkg::MAX_REPORT);
        else
            c.limit = rqtrp_pkg::REP_BITS'(in_data.max_count);
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_data  = q_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = cmd_valid && cmd_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= c;
    end

endmodule

>>> src/rqtrp_back.sv
module rqtrp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  rqtrp_pkg::cmd_t      cmd_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rqtrp_pkg::out_item_t out_data
);

    localparam int AB = rqtrp_pkg::ADDR_BITS;
    localparam int CB = rqtrp_pkg::CNT_BITS;
    localparam int RB = rqtrp_pkg::REP_BITS;

    rqtrp_pkg::entry_t mem [rqtrp_pkg::MAX_POINTS];

    rqtrp_pkg::back_state_t state_reg, state_next;
    rqtrp_pkg::cmd_t   cmd_reg;
    logic [CB-1:0]     count_reg;
    logic [CB-1:0]     idx_reg, idx_next;   // load: slot being filled; query: read index
    logic [RB-1:0]     found_reg, found_next;
    logic              pend_reg, pend_next; // held match waiting for its successor
    rqtrp_pkg::entry_t pend_ent_reg;
    rqtrp_pkg::entry_t rd_reg;
    logic              ovalid_reg;
    rqtrp_pkg::out_item_t odata_reg;

    logic              rd_en, wr_en;
    logic [AB-1:0]     rd_addr, wr_addr;
    rqtrp_pkg::entry_t wr_data;
    logic              emit;
    rqtrp_pkg::out_item_t emit_data;
    logic              take_cmd, match, oslot;

    assign oslot     = !ovalid_reg || out_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign take_cmd  = cmd_valid && cmd_ready;
    assign match = (rd_reg.x >= cmd_reg.low_x) && (rd_reg.x <= cmd_reg.high_x)
                && (rd_reg.y >= cmd_reg.low_y) && (rd_reg.y <= cmd_reg.high_y);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rqtrp_pkg::ST_IDLE:
                if (take_cmd)
                begin
                    if (cmd_data.is_query)
                        state_next = (count_reg == '0) ? rqtrp_pkg::ST_Q_FLUSH
                                                       : rqtrp_pkg::ST_Q_RD;
                    else if (32'(count_reg) < rqtrp_pkg::MAX_POINTS)
                        state_next = (count_reg == '0) ? rqtrp_pkg::ST_LOAD_DONE
                                                       : rqtrp_pkg::ST_LOAD_RD;
                end
            rqtrp_pkg::ST_LOAD_RD:    state_next = rqtrp_pkg::ST_LOAD_SHIFT;
            rqtrp_pkg::ST_LOAD_SHIFT:
                if (rd_reg.rank <= cmd_reg.pt.rank || idx_reg == CB'(1))
                    state_next = rqtrp_pkg::ST_LOAD_DONE;
                else
                    state_next = rqtrp_pkg::ST_LOAD_RD;
            rqtrp_pkg::ST_LOAD_DONE:  state_next = rqtrp_pkg::ST_IDLE;
            rqtrp_pkg::ST_Q_RD:       state_next = rqtrp_pkg::ST_Q_CHK;
            rqtrp_pkg::ST_Q_CHK:
                if (!(match && pend_reg && !oslot))
                begin
                    if ((match && found_reg + RB'(1) == cmd_reg.limit)
                        || idx_reg == count_reg)
                        state_next = rqtrp_pkg::ST_Q_FLUSH;
                    else
                        state_next = rqtrp_pkg::ST_Q_RD;
                end
            rqtrp_pkg::ST_Q_FLUSH:
                if (oslot)
                    state_next = rqtrp_pkg::ST_IDLE;
            default: state_next = rqtrp_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_ready  = (state_reg == rqtrp_pkg::ST_IDLE);
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = rd_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        pend_next  = pend_reg;
        emit       = 1'b0;
        emit_data  = '0;
        case (state_reg)
            rqtrp_pkg::ST_IDLE:
                if (take_cmd)
                begin
                    idx_next   = cmd_data.is_query ? '0 : count_reg;
                    found_next = '0;
                    pend_next  = 1'b0;
                end
            rqtrp_pkg::ST_LOAD_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = AB'(idx_reg - CB'(1));
            end
            rqtrp_pkg::ST_LOAD_SHIFT:
                if (!(rd_reg.rank <= cmd_reg.pt.rank))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = AB'(idx_reg);
                    idx_next = idx_reg - CB'(1);
                end
            rqtrp_pkg::ST_LOAD_DONE:
            begin
                wr_en   = 1'b1;
                wr_addr = AB'(idx_reg);
                wr_data = cmd_reg.pt;
            end
            rqtrp_pkg::ST_Q_RD:
            begin
                rd_en    = 1'b1;
                rd_addr  = AB'(idx_reg);
                idx_next = idx_reg + CB'(1);
            end
            rqtrp_pkg::ST_Q_CHK:
                if (match)
                begin
                    if (pend_reg)
                    begin
                        if (oslot)
                        begin
                            emit = 1'b1;
                            emit_data = {1'b1, pend_ent_reg.id, pend_ent_reg.rank,
                                         pend_ent_reg.x, pend_ent_reg.y, 1'b0};
                            found_next = found_reg + RB'(1);
                        end
                    end
                    else
                        found_next = found_reg + RB'(1);
                    if (!pend_reg || oslot)
                        pend_next = 1'b1;
                end
            rqtrp_pkg::ST_Q_FLUSH:
                if (oslot)
                begin
                    emit = 1'b1;
                    if (pend_reg)
                        emit_data = {1'b1, pend_ent_reg.id, pend_ent_reg.rank,
                                     pend_ent_reg.x, pend_ent_reg.y, 1'b1};
                    else
                        emit_data = {1'b0, 8'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1};
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rqtrp_pkg::ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            found_reg  <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            pend_reg  <= pend_next;
            if (state_reg == rqtrp_pkg::ST_LOAD_DONE)
                count_reg <= count_reg + CB'(1);
            if (emit)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cmd)
            cmd_reg <= cmd_data;
        if (emit)
            odata_reg <= emit_data;
        if (state_reg == rqtrp_pkg::ST_Q_CHK && match && (!pend_reg || oslot))
            pend_ent_reg <= rd_reg;
        if (rd_en)
            rd_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

endmodule

>>> src/rect_query_top_ranked_points.sv
// rank-ordered point store with rectangle query
// input channel: in_valid / in_ready carry one transaction of type in_item_t;
//   func 0 inserts a point at its rank position (dropped when the store is full),
//   func 1 runs a rectangle query with a count limit of 1..64
// output channel: out_valid / out_ready carry out_item_t results in rank order,
//   last marks the final result; a query with no match gives one hit=0 result
// a two-entry command queue decouples the input side from the store sequencer
// insert: after the accept, each entry ranked above the new point is shifted up (one
//   store read, one store write), a read of an entry whose rank does not exceed the
//   new point's stops the shift (or it ends at slot 0), then the point is written
// query: after the accept, each store entry is visited (read, then compare) in rank
//   order until the limit is reached, then a flush step emits the final result
// reset clears the point count and control state; store contents need no clearing
// a stalled receiver holds the result register, and the query pauses on the
//   next match until the register frees up; inputs queue until it fills
module rect_query_top_ranked_points (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rqtrp_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rqtrp_pkg::out_item_t out_data
);

    // command handoff between front and back
    logic            cmd_valid;
    logic            cmd_ready;
    rqtrp_pkg::cmd_t cmd_data;

    rqtrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    rqtrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> tb/rect_query_top_ranked_points_checker.sv
`timescale 1ns / 1ps

module rect_query_top_ranked_points_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  rqtrp_pkg::in_item_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  rqtrp_pkg::out_item_t out_data,
    output int                   fail_count,
    output int                   pending,
    output int                   query_count,
    output int                   result_count
);

    rqtrp_pkg::entry_t    store_pts [rqtrp_pkg::MAX_POINTS];
    int                   store_used;
    rqtrp_pkg::out_item_t expected_results [$];

    assign pending = expected_results.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // sorted insert, equal ranks go behind existing ones
    task automatic insert_point(input rqtrp_pkg::in_item_t it);
        int pos;
        pos = store_used;
        if (store_used >= rqtrp_pkg::MAX_POINTS)
            return;
        while (pos > 0 && store_pts[pos-1].rank > it.point_rank)
            pos--;
        for (int j = store_used; j > pos; j--)
            store_pts[j] = store_pts[j-1];
        store_pts[pos] = '{id: it.point_id, rank: it.point_rank,
                           x: it.point_x, y: it.point_y};
        store_used++;
    endtask

    task automatic predict_query(input rqtrp_pkg::in_item_t it);
        int                   limit;
        int                   found;
        rqtrp_pkg::out_item_t r;
        limit = it.max_count;
        if (limit < 1) limit = 1;
        if (limit > rqtrp_pkg::MAX_REPORT) limit = rqtrp_pkg::MAX_REPORT;
        found = 0;
        for (int i = 0; i < store_used && found < limit; i++) begin
            if (store_pts[i].x >= it.low_x && store_pts[i].x <= it.high_x &&
                store_pts[i].y >= it.low_y && store_pts[i].y <= it.high_y)
            begin
                r = '{hit: 1'b1, out_id: store_pts[i].id, out_rank: store_pts[i].rank,
                      out_x: store_pts[i].x, out_y: store_pts[i].y, last: 1'b0};
                expected_results.push_back(r);
                found++;
            end
        end
        if (found == 0) begin
            r = '0;
            r.last = 1'b1;
            expected_results.push_back(r);
        end
        else
            expected_results[$].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rqtrp_pkg::out_item_t w;
        if (!rst_n) begin
            store_used   = 0;
            fail_count   = 0;
            query_count  = 0;
            result_count = 0;
            expected_results.delete();
        end
        else begin
            if (out_valid && out_ready) begin
                result_count++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 64'(out_data.out_rank), 64'd0);
                else begin
                    w = expected_results.pop_front();
                    if (out_data.hit !== w.hit)
                        report_mismatch("hit", 64'(out_data.hit), 64'(w.hit));
                    if (out_data.out_id !== w.out_id)
                        report_mismatch("out_id", 64'(out_data.out_id), 64'(w.out_id));
                    if (out_data.out_rank !== w.out_rank)
                        report_mismatch("out_rank", 64'(out_data.out_rank),
                                        64'(w.out_rank));
                    if (out_data.out_x !== w.out_x)
                        report_mismatch("out_x", 64'(out_data.out_x), 64'(w.out_x));
                    if (out_data.out_y !== w.out_y)
                        report_mismatch("out_y", 64'(out_data.out_y), 64'(w.out_y));
                    if (out_data.last !== w.last)
                        report_mismatch("last", 64'(out_data.last), 64'(w.last));
                end
            end
            if (in_valid && in_ready) begin
                if (in_data.func == rqtrp_pkg::FUNC_LOAD)
                    insert_point(in_data);
                else begin
                    query_count++;
                    predict_query(in_data);
                end
            end
        end
    end

endmodule

>>> tb/rect_query_top_ranked_points_tb.sv
`timescale 1ns / 1ps

module rect_query_top_ranked_points_tb;

    localparam int N_RANDOM   = 294;
    // covers a full-store insert or scan, plus stalls on 64 results
    localparam int IDLE_LIMIT = 40000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    rqtrp_pkg::in_item_t  in_data;
    logic                 out_valid;
    logic                 out_ready;
    rqtrp_pkg::out_item_t out_data;
    int                   fail_count;
    int                   pending;
    int                   query_count;
    int                   result_count;
    int                   idle_cycles;
    int                   loads_sent;

    rect_query_top_ranked_points u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    rect_query_top_ranked_points_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .query_count (query_count),
        .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stall pattern: phases of always-ready, light and heavy stalls
    initial
    begin
        int mode;
        out_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 200)) begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog: any cycle without a transaction on either side counts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
            $display("rect_query_top_ranked_points_tb: errors");
            $finish;
        end
    end

    // random signed coordinate: mostly small range so rectangles hit, some extremes
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    // one transaction: hold valid until accepted; ready is looked at mid-cycle
    task automatic send(input rqtrp_pkg::in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    int burst_left;

    task automatic send_paced(input rqtrp_pkg::in_item_t it);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send(it);
    endtask

    function automatic rqtrp_pkg::in_item_t make_load(input logic [7:0] id,
                                                      input logic signed [31:0] rank,
                                                      input logic signed [31:0] x,
                                                      input logic signed [31:0] y);
        rqtrp_pkg::in_item_t it;
        logic [287:0]        raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom()};
        it = raw[$bits(rqtrp_pkg::in_item_t)-1:0];
        it.func = rqtrp_pkg::FUNC_LOAD;
        it.point_id = id;
        it.point_rank = rank;
        it.point_x = x;
        it.point_y = y;
        return it;
    endfunction

    function automatic rqtrp_pkg::in_item_t make_query(input logic signed [31:0] lx,
                                                       input logic signed [31:0] hx,
                                                       input logic signed [31:0] ly,
                                                       input logic signed [31:0] hy,
                                                       input logic [6:0] cnt);
        rqtrp_pkg::in_item_t it;
        logic [287:0]        raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom()};
        it = raw[$bits(rqtrp_pkg::in_item_t)-1:0];
        it.func = rqtrp_pkg::FUNC_QUERY;
        it.low_x = lx;
        it.high_x = hx;
        it.low_y = ly;
        it.high_y = hy;
        it.max_count = cnt;
        return it;
    endfunction

    initial
    begin
        rqtrp_pkg::in_item_t it;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        burst_left  = 0;
        loads_sent  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: query on empty store, extreme fields, equal ranks,
        // empty rectangle, count extremes, all-ones / all-zeros bits
        send(make_query(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                        32'sh7fff_ffff, 7'd1));
        send(make_load(8'hff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000));
        send(make_load(8'h00, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff));
        send(make_load(8'h55, 32'sd5, -32'sd1, 32'sd0));
        send(make_load(8'haa, 32'sd5, 32'sd0, -32'sd1));
        send(make_load(8'h0f, -32'sd1, 32'sd3, 32'sd3));
        send(make_load(8'hf0, 32'sd0, 32'sh8000_0000, 32'sh8000_0000));
        send(make_query(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                        32'sh7fff_ffff, 7'd64));
        send(make_query(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                        32'sh7fff_ffff, 7'd1));
        send(make_query(32'sd1, 32'sd0, 32'sh8000_0000, 32'sh7fff_ffff, 7'd64));
        send(make_query(32'sd3, 32'sd3, 32'sd3, 32'sd3, 7'd2));
        send(make_query(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                        32'sh8000_0000, 7'd64));
        send(make_query(-32'sd1, 32'sd0, -32'sd1, 32'sd0, 7'd3));
        send(make_query(32'sd100, 32'sd200, 32'sd100, 32'sd200, 7'd10));
        loads_sent = 6;

        // random: mostly loads early, then a query mix
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 99) < (n < 60 ? 75 : 45)) begin
                it = make_load(8'($urandom()), $urandom_range(0, 3) == 0 ? $urandom()
                               : $signed($urandom_range(0, 40)) - 20,
                               rand_coord(), rand_coord());
                loads_sent++;
            end
            else if ($urandom_range(0, 7) == 0)
                it = make_query(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                                32'sh7fff_ffff, 7'($urandom_range(1, 64)));
            else
                it = make_query($signed($urandom_range(0, 120)) - 110,
                                $signed($urandom_range(0, 120)) - 10,
                                $signed($urandom_range(0, 120)) - 110,
                                $signed($urandom_range(0, 120)) - 10,
                                $urandom_range(0, 3) == 0 ? 7'd64
                                : 7'($urandom_range(1, 64)));
            send_paced(it);
        end

        // closing full-range scan and a narrow one
        send_paced(make_query(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                              32'sh7fff_ffff, 7'd64));
        send_paced(make_query(32'sd50, 32'sd60, 32'sd50, 32'sd60, 7'd64));
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("covered %0d loads and %0d queries, %0d results checked",
                 loads_sent, query_count, result_count);
        if (fail_count == 0)
            $display("rect_query_top_ranked_points_tb: clean");
        else
            $display("rect_query_top_ranked_points_tb: errors");
        $finish;
    end

endmodule
